@@ rtl/rfpwc_pkg.sv @@
// Shared types and constants for the RF pulse width capture block.
package rfpwc_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_MIN_WIDTH     = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH     = 2'd1;
    localparam logic [1:0] REG_SILENCE_LIMIT = 2'd2;
    localparam logic [1:0] REG_MIN_PULSES    = 2'd3;

    localparam logic [11:0] MIN_WIDTH_RST     = 12'd300;
    localparam logic [11:0] MAX_WIDTH_RST     = 12'd2500;
    localparam logic [15:0] SILENCE_LIMIT_RST = 16'd25000;
    localparam logic [9:0]  MIN_PULSES_RST    = 10'd45;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic [2:0] KIND_NONE         = 3'd0;
    localparam logic [2:0] KIND_FRAME_READY  = 3'd1;
    localparam logic [2:0] KIND_PULSE        = 3'd2;
    localparam logic [2:0] KIND_FRAME_DROP   = 3'd3;
    localparam logic [2:0] KIND_NOTHING_HELD = 3'd4;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    typedef struct packed {
        logic mode;
        logic pin_level;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] pulse_width;
        logic        pulse_level;
        logic [9:0]  pulse_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [11:0] min_width;
        logic [11:0] max_width;
        logic [15:0] silence_limit;
        logic [9:0]  min_pulses;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        wr_en;
        logic        rd_en;
        logic [11:0] width;
        logic        level;
        logic [9:0]  count;
        logic        last;
    } cmd_t;

endpackage

@@ rtl/rfpwc_front.sv @@
// Front end: takes sample and read transactions, tracks edges and frames, issues commands.
module rfpwc_front #(
    parameter int MAX_PULSES = 512,
    parameter int ADDR_W     = 9,
    parameter int CNT_W      = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  rfpwc_pkg::item_t     item,
    input  rfpwc_pkg::cfg_t      cfg,
    output rfpwc_pkg::cmd_t      cmd,
    output logic [ADDR_W-1:0]    cmd_addr
);

    localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

    logic             prev_level_reg, prev_level_next;
    logic [15:0]      ticks_reg, ticks_next;
    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic             frame_held_reg, frame_held_next;
    logic [CNT_W-1:0] read_index_reg, read_index_next;

    logic [15:0]      t_inc;
    logic [CNT_W-1:0] read_index_inc;
    logic             in_window;
    logic             has_room;

    assign t_inc = (ticks_reg == rfpwc_pkg::TICKS_MAX) ? ticks_reg : ticks_reg + 16'd1;
    assign read_index_inc = read_index_reg + CNT_W'(1);
    assign in_window = (t_inc > {4'd0, cfg.min_width}) && (t_inc < {4'd0, cfg.max_width});
    assign has_room = (stored_count_reg < CNT_W'(MAX_PULSES));

    always_comb
    begin
        prev_level_next   = prev_level_reg;
        ticks_next        = ticks_reg;
        stored_count_next = stored_count_reg;
        frame_held_next   = frame_held_reg;
        read_index_next   = read_index_reg;
        cmd               = '0;
        cmd.kind          = rfpwc_pkg::KIND_NONE;
        cmd_addr          = '0;

        if (item.mode == rfpwc_pkg::MODE_READ)
        begin
            if (!frame_held_reg || (read_index_reg >= stored_count_reg))
            begin
                cmd.kind = rfpwc_pkg::KIND_NOTHING_HELD;
            end
            else
            begin
                cmd.kind        = rfpwc_pkg::KIND_PULSE;
                cmd.rd_en       = 1'b1;
                cmd_addr        = read_index_reg[ADDR_W-1:0];
                cmd.count       = 10'(stored_count_reg);
                cmd.last        = (read_index_inc == stored_count_reg);
                read_index_next = read_index_inc;
                if (cmd.last)
                begin
                    frame_held_next   = 1'b0;
                    stored_count_next = '0;
                    read_index_next   = '0;
                end
            end
        end
        else if (!frame_held_reg)
        begin
            if (item.pin_level != prev_level_reg)
            begin
                if (in_window && has_room)
                begin
                    cmd.wr_en         = 1'b1;
                    cmd_addr          = stored_count_reg[ADDR_W-1:0];
                    cmd.width         = t_inc[11:0];
                    cmd.level         = prev_level_reg;
                    stored_count_next = stored_count_reg + CNT_W'(1);
                end
                prev_level_next = item.pin_level;
                ticks_next      = '0;
            end
            else
            begin
                ticks_next = t_inc;
            end

            if ((stored_count_next != '0) && (ticks_next > cfg.silence_limit))
            begin
                cmd.count = 10'(stored_count_next);
                if (CMP_W'(stored_count_next) >= CMP_W'(cfg.min_pulses))
                begin
                    cmd.kind        = rfpwc_pkg::KIND_FRAME_READY;
                    frame_held_next = 1'b1;
                    read_index_next = '0;
                end
                else
                begin
                    cmd.kind          = rfpwc_pkg::KIND_FRAME_DROP;
                    stored_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg   <= 1'b0;
            ticks_reg        <= '0;
            stored_count_reg <= '0;
            frame_held_reg   <= 1'b0;
            read_index_reg   <= '0;
        end
        else if (accept)
        begin
            prev_level_reg   <= prev_level_next;
            ticks_reg        <= ticks_next;
            stored_count_reg <= stored_count_next;
            frame_held_reg   <= frame_held_next;
            read_index_reg   <= read_index_next;
        end
    end

`ifndef ASSERT_OFF
    a_held_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        frame_held_reg |-> (stored_count_reg != '0))
        else $error("held frame with empty store");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_held_reg |-> (read_index_reg < stored_count_reg))
        else $error("read index beyond held frame");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_held_reg |-> (read_index_reg == '0))
        else $error("read index not cleared outside a held frame");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CNT_W'(MAX_PULSES))
        else $error("stored count past store depth");
`endif

endmodule

@@ rtl/rfpwc_queue.sv @@
// Short command queue between front and back end.
module rfpwc_queue #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + (PTR_W+1)'(1)))
        else $error("queue count lost a push");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count past depth");
`endif

endmodule

@@ rtl/rfpwc_back.sv @@
// Back end: pulse store access and the registered result stage.
module rfpwc_back #(
    parameter int MAX_PULSES = 512,
    parameter int ADDR_W     = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  rfpwc_pkg::cmd_t        q_cmd,
    input  logic [ADDR_W-1:0]      q_addr,
    output logic                   q_pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output rfpwc_pkg::result_t     result
);

    logic [12:0]     store_mem [MAX_PULSES];
    logic [12:0]     rd_data_reg;
    rfpwc_pkg::cmd_t out_cmd_reg;
    logic            out_valid_reg;
    logic            is_pulse;

    assign q_pop = q_valid && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.wr_en)
        begin
            store_mem[q_addr] <= {q_cmd.width, q_cmd.level};
        end
        if (q_pop && q_cmd.rd_en)
        begin
            rd_data_reg <= store_mem[q_addr];
        end
        if (q_pop)
        begin
            out_cmd_reg <= q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign is_pulse = (out_cmd_reg.kind == rfpwc_pkg::KIND_PULSE);

    assign result_valid       = out_valid_reg;
    assign result.kind        = out_cmd_reg.kind;
    assign result.pulse_width = is_pulse ? rd_data_reg[12:1] : 12'd0;
    assign result.pulse_level = is_pulse ? rd_data_reg[0] : 1'b0;
    assign result.pulse_count = out_cmd_reg.count;
    assign result.last        = out_cmd_reg.last;

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> !$past(q_pop))
        else $error("result stage overwritten while stalled");

    a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !out_valid_reg) |-> q_pop)
        else $error("empty result stage not refilled");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> !(q_cmd.wr_en && q_cmd.rd_en))
        else $error("command both writes and reads the store");
`endif

endmodule

@@ rtl/rf_pulse_width_capture.sv @@
// Top level of the RF pulse width capture block: register port and wiring.
//
// Usage:
//   item channel (item_valid/item_stall/item): one transaction per receiver
//   tick with mode sample and the pin level, or mode read to fetch the next
//   pulse of a held frame.
//   result channel (result_valid/result_stall/result): exactly one result per
//   item, in order: nothing, frame ready, pulse entry, frame dropped or
//   nothing held.
//   APB port: min_width at 0x0, max_width at 0x4, silence_limit at 0x8,
//   min_pulses at 0xC; write only while no transaction is in flight.
// Result path: a taken item's command is written into the command queue, then the registered result stage.
// Throughput: one item per cycle while item_stall is low; the front end updates all edge and frame
//   state for each taken item and the back end does at most one store access per item.
// Stall: a four-entry command queue decouples the sides; item_stall rises
//   once it is full and stays high while result_stall holds the output.
// Reset: registers return to their defaults, no frame is held, the pulse
//   store content is undefined until written.
module rf_pulse_width_capture #(
    parameter int MAX_PULSES = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  rfpwc_pkg::item_t                  item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output rfpwc_pkg::result_t                result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rfpwc_pkg::PADDR_W-1:0]     paddr,
    input  logic [rfpwc_pkg::PDATA_W-1:0]     pwdata,
    output logic [rfpwc_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam int ADDR_W = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam int CNT_W  = $clog2(MAX_PULSES + 1);
    localparam int CMD_W  = $bits(rfpwc_pkg::cmd_t);
    localparam int Q_W    = ADDR_W + CMD_W;

    rfpwc_pkg::cfg_t cfg_reg;
    logic            cfg_wr;
    logic [1:0]      reg_sel;

    logic            accept;
    rfpwc_pkg::cmd_t f_cmd;
    logic [ADDR_W-1:0] f_addr;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic [Q_W-1:0]  q_data;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_width     <= rfpwc_pkg::MIN_WIDTH_RST;
            cfg_reg.max_width     <= rfpwc_pkg::MAX_WIDTH_RST;
            cfg_reg.silence_limit <= rfpwc_pkg::SILENCE_LIMIT_RST;
            cfg_reg.min_pulses    <= rfpwc_pkg::MIN_PULSES_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                rfpwc_pkg::REG_MIN_WIDTH:     cfg_reg.min_width     <= pwdata[11:0];
                rfpwc_pkg::REG_MAX_WIDTH:     cfg_reg.max_width     <= pwdata[11:0];
                rfpwc_pkg::REG_SILENCE_LIMIT: cfg_reg.silence_limit <= pwdata[15:0];
                rfpwc_pkg::REG_MIN_PULSES:    cfg_reg.min_pulses    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            rfpwc_pkg::REG_MIN_WIDTH:     prdata = {20'd0, cfg_reg.min_width};
            rfpwc_pkg::REG_MAX_WIDTH:     prdata = {20'd0, cfg_reg.max_width};
            rfpwc_pkg::REG_SILENCE_LIMIT: prdata = {16'd0, cfg_reg.silence_limit};
            rfpwc_pkg::REG_MIN_PULSES:    prdata = {22'd0, cfg_reg.min_pulses};
            default:                      prdata = '0;
        endcase
    end

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    rfpwc_front #(
        .MAX_PULSES (MAX_PULSES),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .cmd      (f_cmd),
        .cmd_addr (f_addr)
    );

    rfpwc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({f_addr, f_cmd}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    rfpwc_back #(
        .MAX_PULSES (MAX_PULSES),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_data[CMD_W-1:0]),
        .q_addr       (q_data[Q_W-1:CMD_W]),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ verif/tb_rf_pulse_width_capture.sv @@
// Self-checking testbench for the RF pulse width capture block.
module tb_rf_pulse_width_capture;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 512;
    localparam int IDLE_PCT    = 17;

    localparam rfpwc_pkg::result_t RES_NONE =
        {rfpwc_pkg::KIND_NONE, 12'd0, 1'b0, 10'd0, 1'b0};
    localparam rfpwc_pkg::result_t RES_NOTHING_HELD =
        {rfpwc_pkg::KIND_NOTHING_HELD, 12'd0, 1'b0, 10'd0, 1'b0};
    localparam rfpwc_pkg::result_t RES_DROP_ONE =
        {rfpwc_pkg::KIND_FRAME_DROP, 12'd0, 1'b0, 10'd1, 1'b0};

    typedef struct packed {
        rfpwc_pkg::item_t   stim;
        logic               typed;
        rfpwc_pkg::result_t want;
    } step_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            item_valid;
    logic                            item_stall;
    rfpwc_pkg::item_t                item;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    rfpwc_pkg::result_t              result;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rfpwc_pkg::PADDR_W-1:0]   paddr;
    logic [rfpwc_pkg::PDATA_W-1:0]   pwdata;
    logic [rfpwc_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;

    // capture model state
    rfpwc_pkg::cfg_t      capture_cfg;
    logic                 line_level;
    logic [15:0]          quiet_ticks;
    int                   stored_pulses;
    logic [11:0]          held_widths [STORE_DEPTH];
    logic                 held_levels [STORE_DEPTH];
    logic                 frame_waiting;
    int                   read_ptr;

    rfpwc_pkg::result_t   due_results [$];
    step_row_t            directed_rows [22];
    bit                   steady;
    int                   mismatches;
    int                   n_items;
    int                   n_ready;
    int                   n_dropped;
    int                   n_entries;

    rf_pulse_width_capture #(
        .MAX_PULSES (STORE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("rf_pulse_width_capture regression: fail");
        $finish;
    end

    function automatic rfpwc_pkg::result_t capture_tick(rfpwc_pkg::item_t it);
        rfpwc_pkg::result_t r;
        logic [15:0]        t;
        r = RES_NONE;
        if (it.mode == rfpwc_pkg::MODE_READ)
        begin
            if (!frame_waiting || read_ptr >= stored_pulses)
            begin
                r.kind = rfpwc_pkg::KIND_NOTHING_HELD;
                return r;
            end
            r.kind        = rfpwc_pkg::KIND_PULSE;
            r.pulse_width = held_widths[read_ptr];
            r.pulse_level = held_levels[read_ptr];
            r.pulse_count = stored_pulses[9:0];
            r.last        = (read_ptr + 1 == stored_pulses);
            read_ptr++;
            if (r.last)
            begin
                frame_waiting = 1'b0;
                stored_pulses = 0;
                read_ptr      = 0;
            end
            return r;
        end
        if (frame_waiting)
            return r;
        t = (quiet_ticks < rfpwc_pkg::TICKS_MAX) ? quiet_ticks + 16'd1 : rfpwc_pkg::TICKS_MAX;
        if (it.pin_level != line_level)
        begin
            if (t > capture_cfg.min_width && t < capture_cfg.max_width &&
                stored_pulses < STORE_DEPTH)
            begin
                held_widths[stored_pulses] = t[11:0];
                held_levels[stored_pulses] = line_level;
                stored_pulses++;
            end
            line_level  = it.pin_level;
            quiet_ticks = '0;
        end
        else
            quiet_ticks = t;
        if (stored_pulses > 0 && quiet_ticks > capture_cfg.silence_limit)
        begin
            r.pulse_count = stored_pulses[9:0];
            if (stored_pulses >= capture_cfg.min_pulses)
            begin
                frame_waiting = 1'b1;
                read_ptr      = 0;
                r.kind        = rfpwc_pkg::KIND_FRAME_READY;
            end
            else
            begin
                stored_pulses = 0;
                r.kind        = rfpwc_pkg::KIND_FRAME_DROP;
            end
        end
        return r;
    endfunction

    // result side: check each transaction, stall at random
    always @(posedge clk)
    begin : result_check
        rfpwc_pkg::result_t want;
        if (result_valid && !result_stall)
        begin
            if (due_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: kind %0d width %0d level %0d count %0d last %0d",
                             result.kind, result.pulse_width, result.pulse_level,
                             result.pulse_count, result.last);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result.kind !== want.kind || result.pulse_width !== want.pulse_width ||
                    result.pulse_level !== want.pulse_level ||
                    result.pulse_count !== want.pulse_count || result.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch exp: kind %0d width %0d level %0d count %0d last %0d",
                                 want.kind, want.pulse_width, want.pulse_level,
                                 want.pulse_count, want.last);
                        $display("         got: kind %0d width %0d level %0d count %0d last %0d",
                                 result.kind, result.pulse_width, result.pulse_level,
                                 result.pulse_count, result.last);
                    end
                    mismatches++;
                end
            end
        end
        result_stall <= rst_n && !steady && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic push_item(rfpwc_pkg::item_t it, bit typed = 1'b0,
                             rfpwc_pkg::result_t fixed = RES_NONE);
        rfpwc_pkg::result_t r;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        r = capture_tick(it);
        due_results.push_back(typed ? fixed : r);
        n_items++;
        if (r.kind == rfpwc_pkg::KIND_FRAME_READY)
            n_ready++;
        if (r.kind == rfpwc_pkg::KIND_FRAME_DROP)
            n_dropped++;
        if (r.kind == rfpwc_pkg::KIND_PULSE)
            n_entries++;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        item_valid <= 1'b0;
        while (due_results.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rfpwc_pkg::REG_MIN_WIDTH:     capture_cfg.min_width     = value[11:0];
            rfpwc_pkg::REG_MAX_WIDTH:     capture_cfg.max_width     = value[11:0];
            rfpwc_pkg::REG_SILENCE_LIMIT: capture_cfg.silence_limit = value[15:0];
            default:                      capture_cfg.min_pulses    = value[9:0];
        endcase
    endtask

    task automatic write_cfg(int unsigned min_w, int unsigned max_w,
                             int unsigned quiet, int unsigned min_p);
        wait_idle();
        apb_write(rfpwc_pkg::REG_MIN_WIDTH, min_w);
        apb_write(rfpwc_pkg::REG_MAX_WIDTH, max_w);
        apb_write(rfpwc_pkg::REG_SILENCE_LIMIT, quiet);
        apb_write(rfpwc_pkg::REG_MIN_PULSES, min_p);
    endtask

    // read a held frame out, with the odd ignored sample and a spare read
    task automatic drain_frame();
        while (frame_waiting)
        begin
            if ($urandom_range(99) < 8)
                push_item({rfpwc_pkg::MODE_SAMPLE, 1'($urandom_range(1))});
            else
                push_item({rfpwc_pkg::MODE_READ, 1'($urandom_range(1))});
        end
        if ($urandom_range(9) == 0)
            push_item({rfpwc_pkg::MODE_READ, 1'($urandom_range(1))});
    endtask

    // pulse train starting from the current line level
    task automatic send_pulses(int pulses, int fixed_w);
        logic lvl;
        int   w;
        int   lo;
        int   hi;
        lvl = line_level;
        repeat (pulses)
        begin
            if (fixed_w > 0)
                w = fixed_w;
            else
            begin
                lo = capture_cfg.min_width + 1;
                hi = capture_cfg.max_width - 1;
                if (hi >= lo && $urandom_range(9) != 0)
                    w = $urandom_range(hi, lo);
                else
                    w = $urandom_range(capture_cfg.max_width + 2, 1);
            end
            repeat (w - 1) push_item({rfpwc_pkg::MODE_SAMPLE, lvl});
            lvl = ~lvl;
            push_item({rfpwc_pkg::MODE_SAMPLE, lvl});
        end
    endtask

    // pulse train, then a quiet line long enough to end the frame
    task automatic send_frame(int pulses, int fixed_w);
        int quiet;
        send_pulses(pulses, fixed_w);
        quiet = capture_cfg.silence_limit + 1 + $urandom_range(2);
        repeat (quiet) push_item({rfpwc_pkg::MODE_SAMPLE, line_level});
        drain_frame();
    endtask

    task automatic noise(int n);
        repeat (n)
            push_item({($urandom_range(3) == 0) ? rfpwc_pkg::MODE_READ : rfpwc_pkg::MODE_SAMPLE,
                       1'($urandom_range(1))});
    endtask

    initial
    begin
        int start;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        steady       = 1'b0;
        mismatches   = 0;
        n_items      = 0;
        n_ready      = 0;
        n_dropped    = 0;
        n_entries    = 0;
        capture_cfg   = {rfpwc_pkg::MIN_WIDTH_RST, rfpwc_pkg::MAX_WIDTH_RST,
                         rfpwc_pkg::SILENCE_LIMIT_RST, rfpwc_pkg::MIN_PULSES_RST};
        line_level    = 1'b0;
        quiet_ticks   = '0;
        stored_pulses = 0;
        frame_waiting = 1'b0;
        read_ptr      = 0;

        // window 1 < w < 4, silence 2, two pulses to hold
        directed_rows[0]  = {rfpwc_pkg::MODE_READ,   1'b0, 1'b1, RES_NOTHING_HELD};
        directed_rows[1]  = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b1, RES_NONE};
        directed_rows[2]  = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b1, RES_NONE};
        directed_rows[3]  = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[4]  = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};
        directed_rows[5]  = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};
        directed_rows[6]  = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};
        directed_rows[7]  = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b1, RES_DROP_ONE};
        directed_rows[8]  = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[9]  = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[10] = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};
        directed_rows[11] = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};
        directed_rows[12] = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};
        directed_rows[13] = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[14] = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[15] = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[16] = {rfpwc_pkg::MODE_SAMPLE, 1'b1, 1'b0, RES_NONE};
        directed_rows[17] = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b1, RES_NONE};
        directed_rows[18] = {rfpwc_pkg::MODE_READ,   1'b1, 1'b0, RES_NONE};
        directed_rows[19] = {rfpwc_pkg::MODE_READ,   1'b0, 1'b0, RES_NONE};
        directed_rows[20] = {rfpwc_pkg::MODE_READ,   1'b1, 1'b1, RES_NOTHING_HELD};
        directed_rows[21] = {rfpwc_pkg::MODE_SAMPLE, 1'b0, 1'b0, RES_NONE};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(1, 4, 2, 2);
        foreach (directed_rows[i])
            push_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // long stretch with no idling on either side
        write_cfg(1, 10, 12, 3);
        steady = 1'b1;
        repeat (2) send_frame($urandom_range(6, 1), 0);
        wait_idle();
        steady = 1'b0;

        repeat (2)
        begin
            write_cfg($urandom_range(4), $urandom_range(16, 6), $urandom_range(24, 16),
                      $urandom_range(6));
            start = n_items;
            while (n_items - start < 30)
            begin
                if ($urandom_range(9) < 8)
                    send_frame($urandom_range(6, 1), 0);
                else
                    noise($urandom_range(10, 2));
            end
            drain_frame();
        end

        // empty windows, zero silence limit, zero pulse minimum
        write_cfg(4095, 4095, 3, 0);
        noise(10);
        write_cfg(0, 0, 3, 0);
        noise(10);
        write_cfg(0, 3, 0, 0);
        repeat (4) send_frame($urandom_range(4, 1), 0);

        // fill the store past its depth; too short for the largest minimum
        write_cfg(0, 2, 0, 1023);
        send_frame(STORE_DEPTH + 2, 1);

        // largest silence limit does not end the frame, a lower one does
        write_cfg(1, 4095, 65535, 1);
        send_pulses(3, 5);
        repeat (20) push_item({rfpwc_pkg::MODE_SAMPLE, line_level});
        wait_idle();
        apb_write(rfpwc_pkg::REG_SILENCE_LIMIT, 5);
        push_item({rfpwc_pkg::MODE_SAMPLE, line_level});
        drain_frame();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("%0d transactions: %0d frames held, %0d dropped, %0d pulse entries read",
                 n_items, n_ready, n_dropped, n_entries);
        $display("covered empty and open width windows, zero and largest silence limits, "
                 , "a store filled past its depth");
        if (mismatches == 0 && due_results.size() == 0)
            $display("rf_pulse_width_capture regression: pass");
        else
            $display("rf_pulse_width_capture regression: fail");
        $finish;
    end

endmodule
